// ===== rtl/core/byte_pattern_search_defines.svh =====
// assertion macros shared by the byte pattern search rtl
// needs a clk and an active-low rst_n in the module that uses them
`ifndef BYTE_PATTERN_SEARCH_DEFINES_SVH
`define BYTE_PATTERN_SEARCH_DEFINES_SVH

// property checked at every clock edge outside reset
`define BPS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("byte pattern search assertion failed");

// condition that must never be seen outside reset
`define BPS_ASSERT_NEVER(label, expr) \
  `BPS_ASSERT(label, !(expr))

`endif

// ===== rtl/core/bps_pkg.sv =====
// shared constants, codes and types of the byte pattern search block
// no dependencies
package bps_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int ADDR_BITS   = 48;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [ADDR_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW      = 3'd0,
    REG_PATTERN_HIGH     = 3'd1,
    REG_PATTERN_LENGTH   = 3'd2,
    REG_SEARCH_BACKWARDS = 3'd3,
    REG_START_ADDRESS    = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ST_FOUND     = 1'b0,
    ST_NOT_FOUND = 1'b1
  } status_t;

  typedef logic [PATTERN_MAX-1:0][7:0] win_t;

  // settings worked out from the register file
  typedef struct packed {
    win_t                   expected;
    logic [PATTERN_MAX-1:0] mask;
    logic [LEN_W-1:0]       len;
    logic                   backwards;
    logic [ADDR_BITS-1:0]   base;
  } cfg_t;

  // one accepted word after the window update
  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 last;
    win_t                 window;
    logic [ADDR_BITS-1:0] count;
  } item_t;

  typedef struct packed {
    status_t              status;
    logic [ADDR_BITS-1:0] addr;
  } result_t;

endpackage

// ===== rtl/core/bps_front.sv =====
// front part: register file, window shift and byte count per accepted word
// depends on bps_pkg
module bps_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             accept_i,
  input  logic [7:0]                       data_i,
  input  logic                             first_i,
  input  logic                             last_i,
  output bps_pkg::item_t                   item_o,
  output bps_pkg::cfg_t                    cfg_o
);

  logic [63:0]                   pat_lo_r;
  logic [63:0]                   pat_hi_r;
  logic [bps_pkg::LEN_W-1:0]     len_r;
  logic                          bwd_r;
  logic [bps_pkg::ADDR_BITS-1:0] start_r;

  bps_pkg::cfg_t                 cfg_r;
  bps_pkg::cfg_t                 cfg_nxt;

  bps_pkg::win_t                 win_r;
  bps_pkg::win_t                 win_nxt;
  logic [bps_pkg::ADDR_BITS-1:0] cnt_r;
  logic [bps_pkg::ADDR_BITS-1:0] cnt_nxt;
  bps_pkg::item_t                item_r;
  bps_pkg::item_t                item_nxt;

  bps_pkg::win_t                 pat;
  bps_pkg::win_t                 win_base;
  logic [bps_pkg::ADDR_BITS-1:0] cnt_base;
  logic [bps_pkg::LEN_W-1:0]     len_eff;
  logic [bps_pkg::LEN_W-1:0]     rev_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      len_r    <= bps_pkg::LEN_W'(1);
      bwd_r    <= 1'b0;
      start_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bps_pkg::REG_PATTERN_LOW:      pat_lo_r <= cfg_wdata;
        bps_pkg::REG_PATTERN_HIGH:     pat_hi_r <= cfg_wdata;
        bps_pkg::REG_PATTERN_LENGTH:   len_r    <= cfg_wdata[bps_pkg::LEN_W-1:0];
        bps_pkg::REG_SEARCH_BACKWARDS: bwd_r    <= cfg_wdata[0];
        bps_pkg::REG_START_ADDRESS:    start_r  <= cfg_wdata[bps_pkg::ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // expected bytes line up with the window, newest byte at index 0
  always_comb begin
    pat = {pat_hi_r, pat_lo_r};
    if (len_r == '0) begin
      len_eff = bps_pkg::LEN_W'(1);
    end else if (len_r > bps_pkg::LEN_W'(bps_pkg::PATTERN_MAX)) begin
      len_eff = bps_pkg::LEN_W'(bps_pkg::PATTERN_MAX);
    end else begin
      len_eff = len_r;
    end
    rev_idx = '0;
    cfg_nxt = '0;
    for (int k = 0; k < bps_pkg::PATTERN_MAX; k++) begin
      rev_idx = len_eff - bps_pkg::LEN_W'(1) - bps_pkg::LEN_W'(k);
      cfg_nxt.mask[k] = bps_pkg::LEN_W'(k) < len_eff;
      if (!cfg_nxt.mask[k]) begin
        cfg_nxt.expected[k] = 8'h00;
      end else if (bwd_r) begin
        cfg_nxt.expected[k] = pat[k];
      end else begin
        cfg_nxt.expected[k] = pat[rev_idx[bps_pkg::IDX_W-1:0]];
      end
    end
    cfg_nxt.len       = len_eff;
    cfg_nxt.backwards = bwd_r;
    cfg_nxt.base      = bwd_r ? start_r
                              : start_r - bps_pkg::ADDR_BITS'(len_eff);
  end

  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  always_comb begin
    win_base = first_i ? '0 : win_r;
    cnt_base = first_i ? '0 : cnt_r;
    win_nxt  = win_r;
    cnt_nxt  = cnt_r;
    item_nxt = item_r;
    item_nxt.valid = accept_i;
    if (accept_i) begin
      win_nxt = {win_base[bps_pkg::PATTERN_MAX-2:0], data_i};
      cnt_nxt = (cnt_base == bps_pkg::COUNT_MAX) ? cnt_base
                                                 : cnt_base + bps_pkg::ADDR_BITS'(1);
      item_nxt.first  = first_i;
      item_nxt.last   = last_i;
      item_nxt.window = win_nxt;
      item_nxt.count  = cnt_nxt;
    end
  end

  // only the valid bit of the stage register needs a reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= '0;
      cnt_r        <= '0;
      item_r.valid <= 1'b0;
    end else begin
      win_r        <= win_nxt;
      cnt_r        <= cnt_nxt;
      item_r.valid <= item_nxt.valid;
    end
    item_r.first  <= item_nxt.first;
    item_r.last   <= item_nxt.last;
    item_r.window <= item_nxt.window;
    item_r.count  <= item_nxt.count;
  end

  assign item_o = item_r;
  assign cfg_o  = cfg_r;

endmodule

// ===== rtl/core/bps_match.sv =====
// window compare, match address and one-result-per-search tracking
// depends on bps_pkg and byte_pattern_search_defines.svh
`include "byte_pattern_search_defines.svh"

module bps_match (
  input  logic               clk,
  input  logic               rst_n,
  input  bps_pkg::item_t     item_i,
  input  bps_pkg::cfg_t      cfg_i,
  output logic               push_o,
  output bps_pkg::result_t   result_o
);

  logic                         done_r;
  logic                         done_nxt;
  logic                         done_eff;
  logic [bps_pkg::PATTERN_MAX-1:0] eq;
  logic                         match;

  always_comb begin
    for (int k = 0; k < bps_pkg::PATTERN_MAX; k++) begin
      eq[k] = !cfg_i.mask[k] || (item_i.window[k] == cfg_i.expected[k]);
    end
    match    = (&eq) && (item_i.count >= bps_pkg::ADDR_BITS'(cfg_i.len));
    done_eff = item_i.first ? 1'b0 : done_r;
    push_o   = item_i.valid && !done_eff && (match || item_i.last);
    result_o.status = match ? bps_pkg::ST_FOUND : bps_pkg::ST_NOT_FOUND;
    if (!match) begin
      result_o.addr = '0;
    end else if (cfg_i.backwards) begin
      result_o.addr = cfg_i.base - item_i.count;
    end else begin
      result_o.addr = cfg_i.base + item_i.count;
    end
    done_nxt = item_i.valid ? (done_eff || push_o) : done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  // a finished search stays silent until a first word arrives
  `BPS_ASSERT(a_one_result_per_search, push_o |=> !(push_o && !item_i.first))

endmodule

// ===== rtl/core/bps_queue.sv =====
// result queue between compare and output channel, head drives the port
// depends on bps_pkg and byte_pattern_search_defines.svh
`include "byte_pattern_search_defines.svh"

module bps_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push_i,
  input  bps_pkg::result_t             data_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output bps_pkg::result_t             data_o,
  output logic [bps_pkg::Q_CNT_W-1:0]  count_o
);

  bps_pkg::result_t             mem [bps_pkg::Q_DEPTH];
  logic [bps_pkg::Q_PTR_W-1:0]  wr_ptr_r;
  logic [bps_pkg::Q_PTR_W-1:0]  wr_ptr_nxt;
  logic [bps_pkg::Q_PTR_W-1:0]  rd_ptr_r;
  logic [bps_pkg::Q_PTR_W-1:0]  rd_ptr_nxt;
  logic [bps_pkg::Q_CNT_W-1:0]  cnt_r;
  logic [bps_pkg::Q_CNT_W-1:0]  cnt_nxt;
  logic                         do_pop;

  always_comb begin
    do_pop     = pop_i && (cnt_r != '0);
    wr_ptr_nxt = push_i ? wr_ptr_r + bps_pkg::Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + bps_pkg::Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + bps_pkg::Q_CNT_W'(push_i) - bps_pkg::Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wr_ptr_r] <= data_i;
    end
  end

  assign valid_o = cnt_r != '0;
  assign data_o  = mem[rd_ptr_r];
  assign count_o = cnt_r;

  `BPS_ASSERT_NEVER(a_no_overflow, push_i && (cnt_r == bps_pkg::Q_CNT_W'(bps_pkg::Q_DEPTH)))
  `BPS_ASSERT(a_count_holds, (!push_i && !do_pop) |=> $stable(cnt_r))
  `BPS_ASSERT(a_head_holds, (valid_o && !pop_i) |=> $stable(data_o))

endmodule

// ===== rtl/core/byte_pattern_search.sv =====
// top level of the byte pattern search block
// depends on bps_pkg, bps_front, bps_match and bps_queue
//
// Content bytes enter on the in_ stream, one word per byte in search order;
// in_tuser flags the first byte of a search, in_tlast the last one. Each
// search yields exactly one word on the out_ stream: out_tuser low with the
// match address in out_tdata, or out_tuser high and address zero when the
// last byte passed without a match. After a result the block drops further
// results until the next first byte.
// Throughput is one byte per cycle while in_tready is high; the window
// compare of all pattern bytes is done in parallel. The byte that completes
// a result is registered in the front stage, compared, and its result is
// written into the queue, whose nonzero count drives out_tvalid.
// A four-entry result queue sits between compare and output. When the
// receiver stalls the queue fills and in_tready drops once the queue plus
// the word in the compare stage would fill it; nothing is lost.
// The user must write configuration through cfg_we/cfg_index/cfg_wdata
// only while the block is idle; the block does not enforce it. A write goes
// to the register file, then cfg_r. Synchronous reset clears the window,
// byte count, done flag, queue and config registers (length resets to one).
module byte_pattern_search (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  logic                            in_tuser,   // [0] first_byte
  input  logic                            in_tlast,   // last_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata,  // [47:0] match_address
  output logic                            out_tuser   // [0] status
);

  bps_pkg::item_t                item;
  bps_pkg::cfg_t                 cfg;
  logic                          push;
  bps_pkg::result_t              result;
  bps_pkg::result_t              head;
  logic [bps_pkg::Q_CNT_W-1:0]   q_count;
  logic                          accept;

  // leave room for the word still in the compare stage
  assign in_tready = (q_count + bps_pkg::Q_CNT_W'(item.valid))
                     < bps_pkg::Q_CNT_W'(bps_pkg::Q_DEPTH);
  assign accept    = in_tvalid && in_tready;

  bps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept_i  (accept),
    .data_i    (in_tdata),
    .first_i   (in_tuser),
    .last_i    (in_tlast),
    .item_o    (item),
    .cfg_o     (cfg)
  );

  bps_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_i   (item),
    .cfg_i    (cfg),
    .push_o   (push),
    .result_o (result)
  );

  bps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  (result),
    .pop_i   (out_tready),
    .valid_o (out_tvalid),
    .data_o  (head),
    .count_o (q_count)
  );

  assign out_tdata = head.addr;
  assign out_tuser = head.status;

endmodule
